// ----- rtl/valid_2d_cross_correlation_assert.svh -----
// Assertion macros for the correlation block. Both sample on the rising
// edge of clk and are switched off while rst is high.
`ifndef VALID_2D_CROSS_CORRELATION_ASSERT_SVH
`define VALID_2D_CROSS_CORRELATION_ASSERT_SVH

// A condition that must hold at every edge.
`define VCC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("valid_2d_cross_correlation: invariant violated");

// A condition that must hold at the edge after a trigger.
`define VCC_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("valid_2d_cross_correlation: sequence violated");

`endif

// ----- rtl/vcc_pkg.sv -----
package vcc_pkg;

  // Geometry limits.
  localparam int MAX_COLUMNS     = 1024;
  localparam int MAX_KERNEL_SIDE = 5;
  localparam int MAX_IMAGE_ROWS  = 4096;

  // Field widths of the channels.
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 40;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int KIDX_W     = 5;
  localparam int ROW_OUT_W  = 12;
  localparam int COL_OUT_W  = 10;
  localparam int IMG_COLS_W = 11;
  localparam int IMG_ROWS_W = 13;
  localparam int KSIDE_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Internal widths.
  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int ROW_W      = $clog2(MAX_IMAGE_ROWS);
  localparam int COLS_REG_W = $clog2(MAX_COLUMNS + 1);
  localparam int LB_ROWS    = (MAX_KERNEL_SIDE > 1) ? MAX_KERNEL_SIDE - 1 : 1;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_COLUMNS  = 2'd0,
    REG_IMAGE_ROWS     = 2'd1,
    REG_KERNEL_ROWS    = 2'd2,
    REG_KERNEL_COLUMNS = 2'd3
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [ROW_OUT_W-1:0]    out_row;
    logic [COL_OUT_W-1:0]    out_col;
    logic                    last;
  } result_t;

  // Position information that travels with a sample down the pipeline.
  typedef struct packed {
    logic                 produce;
    logic                 last;
    logic [ROW_OUT_W-1:0] top;
    logic [COL_OUT_W-1:0] left;
  } tag_t;

endpackage

// ----- rtl/vcc_if.sv -----
interface vcc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [vcc_pkg::KIDX_W-1:0]          kernel_index;
  logic signed [vcc_pkg::SAMPLE_W-1:0] value;

  modport source(output valid, mode, kernel_index, value, input ready);
  modport sink(input valid, mode, kernel_index, value, output ready);
endinterface

interface vcc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [vcc_pkg::SUM_W-1:0] sum;
  logic [vcc_pkg::ROW_OUT_W-1:0]    out_row;
  logic [vcc_pkg::COL_OUT_W-1:0]    out_col;
  logic                             last;

  modport source(output valid, sum, out_row, out_col, last, input ready);
  modport sink(input valid, sum, out_row, out_col, last, output ready);
endinterface

interface vcc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vcc_pkg::CFG_IDX_W-1:0]   index;
  logic [vcc_pkg::CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/valid_2d_cross_correlation.sv -----
// Valid-mode 2D cross-correlation over a raster sample stream. A request with
// mode 0 loads one kernel coefficient (index row*5+column); a request with
// mode 1 delivers the next image sample in raster order. Every window position
// that lies fully inside the image gives one exact 40-bit sum with its output
// row and column, and last marks the final result of the frame. The block takes
// one request per clock cycle while the output queue has room; a result is
// offered once it has left the pipeline. Results wait in an eight-entry output
// queue, and the input is held off only when the queue together with the
// results still in flight would fill it, so a slow consumer stalls the input
// but a waiting result never does by itself. The previous kernel rows are kept
// in one line memory of MAX_COLUMNS words, each word holding one column of the
// last four rows; it is read and written once per sample and needs no clearing
// pass after reset. Configuration writes restart the frame and are taken at once.
`include "valid_2d_cross_correlation_assert.svh"

module valid_2d_cross_correlation (
  input logic        clk,
  input logic        rst,
  vcc_cfg_if.sink    cfg,
  vcc_in_if.sink     din,
  vcc_out_if.source  dout
);

  localparam int K  = vcc_pkg::MAX_KERNEL_SIDE;
  localparam int W  = vcc_pkg::SAMPLE_W;
  localparam int FD = vcc_pkg::FIFO_DEPTH;
  localparam int AW = vcc_pkg::FIFO_AW;

  typedef logic [vcc_pkg::LB_ROWS-1:0][W-1:0] lb_word_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Zero is taken as one and large values saturate.
  // Any write restarts the frame.
  // ---------------------------------------------------------------------------
  logic [vcc_pkg::COLS_REG_W-1:0] img_cols;
  logic [vcc_pkg::IMG_ROWS_W-1:0] img_rows;
  logic [vcc_pkg::KSIDE_W-1:0]    ker_rows;
  logic [vcc_pkg::KSIDE_W-1:0]    ker_cols;

  logic                           cfg_wr;
  logic [vcc_pkg::IMG_COLS_W-1:0] cols_in;
  logic [vcc_pkg::IMG_ROWS_W-1:0] rows_in;
  logic [vcc_pkg::KSIDE_W-1:0]    kr_in;
  logic [vcc_pkg::KSIDE_W-1:0]    kc_in;
  logic [vcc_pkg::COLS_REG_W-1:0] cols_clamp;
  logic [vcc_pkg::IMG_ROWS_W-1:0] rows_clamp;
  logic [vcc_pkg::KSIDE_W-1:0]    kr_clamp;
  logic [vcc_pkg::KSIDE_W-1:0]    kc_clamp;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_comb begin
    cols_in = cfg.data[vcc_pkg::IMG_COLS_W-1:0];
    rows_in = cfg.data[vcc_pkg::IMG_ROWS_W-1:0];
    kr_in   = cfg.data[vcc_pkg::KSIDE_W-1:0];
    kc_in   = cfg.data[vcc_pkg::KSIDE_W-1:0];

    if (cols_in == '0) begin
      cols_clamp = vcc_pkg::COLS_REG_W'(1);
    end else if (cols_in > vcc_pkg::MAX_COLUMNS) begin
      cols_clamp = vcc_pkg::COLS_REG_W'(vcc_pkg::MAX_COLUMNS);
    end else begin
      cols_clamp = vcc_pkg::COLS_REG_W'(cols_in);
    end

    if (rows_in == '0) begin
      rows_clamp = vcc_pkg::IMG_ROWS_W'(1);
    end else if (rows_in > vcc_pkg::MAX_IMAGE_ROWS) begin
      rows_clamp = vcc_pkg::IMG_ROWS_W'(vcc_pkg::MAX_IMAGE_ROWS);
    end else begin
      rows_clamp = rows_in;
    end

    if (kr_in == '0) begin
      kr_clamp = vcc_pkg::KSIDE_W'(1);
    end else if (kr_in > K) begin
      kr_clamp = vcc_pkg::KSIDE_W'(K);
    end else begin
      kr_clamp = kr_in;
    end

    if (kc_in == '0) begin
      kc_clamp = vcc_pkg::KSIDE_W'(1);
    end else if (kc_in > K) begin
      kc_clamp = vcc_pkg::KSIDE_W'(K);
    end else begin
      kc_clamp = kc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_cols <= vcc_pkg::COLS_REG_W'(1);
      img_rows <= vcc_pkg::IMG_ROWS_W'(1);
      ker_rows <= vcc_pkg::KSIDE_W'(1);
      ker_cols <= vcc_pkg::KSIDE_W'(1);
    end else if (cfg_wr) begin
      unique case (vcc_pkg::cfg_reg_t'(cfg.index))
        vcc_pkg::REG_IMAGE_COLUMNS:  img_cols <= cols_clamp;
        vcc_pkg::REG_IMAGE_ROWS:     img_rows <= rows_clamp;
        vcc_pkg::REG_KERNEL_ROWS:    ker_rows <= kr_clamp;
        vcc_pkg::REG_KERNEL_COLUMNS: ker_cols <= kc_clamp;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position. The counters always point at the next sample of the
  // frame; the position flags of that sample are worked out here, before the
  // sample is registered.
  // ---------------------------------------------------------------------------
  logic [vcc_pkg::COL_W-1:0] col_cnt;
  logic [vcc_pkg::ROW_W-1:0] row_cnt;
  logic [vcc_pkg::COL_W:0]   col_inc;
  logic [vcc_pkg::ROW_W:0]   row_inc;
  logic [vcc_pkg::COL_W:0]   left_full;
  logic [vcc_pkg::ROW_W:0]   top_full;
  logic                      col_end;
  logic                      row_end;
  logic                      last_now;
  logic                      produce_now;
  logic [vcc_pkg::COL_W:0]   col_ext;

  logic acc;
  logic acc_smp;

  assign acc     = din.valid && din.ready;
  assign acc_smp = acc && din.mode;

  always_comb begin
    col_inc   = (vcc_pkg::COL_W + 1)'(col_cnt) + (vcc_pkg::COL_W + 1)'(1);
    row_inc   = (vcc_pkg::ROW_W + 1)'(row_cnt) + (vcc_pkg::ROW_W + 1)'(1);
    col_ext   = (vcc_pkg::COL_W + 1)'(col_cnt);
    left_full = col_inc - (vcc_pkg::COL_W + 1)'(ker_cols);
    top_full  = row_inc - (vcc_pkg::ROW_W + 1)'(ker_rows);
    col_end   = (col_inc == img_cols);
    row_end   = (row_inc == img_rows);
    last_now  = col_end && row_end;
    // A window fits only when the kernel fits the image and enough rows and
    // columns of the frame have arrived.
    produce_now = (ker_rows <= img_rows) && (ker_cols <= img_cols) &&
                  (row_inc >= ker_rows) && (col_inc >= ker_cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cfg_wr) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (acc_smp) begin
      if (col_end) begin
        col_cnt <= '0;
        row_cnt <= row_end ? '0 : row_inc[vcc_pkg::ROW_W-1:0];
      end else begin
        col_cnt <= col_inc[vcc_pkg::COL_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the accepted request, together with the line memory word of its
  // column. When the previous sample was in the same column (a one-column
  // image), its write lands on the same edge as this read, so the word it
  // wrote is forwarded instead.
  // ---------------------------------------------------------------------------
  logic                      s1_valid;
  logic                      s1_mode;
  logic [vcc_pkg::KIDX_W-1:0] s1_kidx;
  vcc_pkg::sample_t          s1_value;
  logic [vcc_pkg::COL_W-1:0] s1_col;
  vcc_pkg::tag_t             s1_tag;
  logic                      s1_fwd;

  lb_word_t lb_mem [vcc_pkg::MAX_COLUMNS];
  lb_word_t lb_rd;
  lb_word_t lb_last;
  lb_word_t lb_cur;
  lb_word_t lb_wr;
  logic     lb_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_tag   <= '0;
    end else begin
      s1_valid       <= acc;
      s1_tag.produce <= acc_smp && produce_now;
      s1_tag.last    <= last_now;
      s1_tag.top     <= vcc_pkg::ROW_OUT_W'(top_full);
      s1_tag.left    <= vcc_pkg::COL_OUT_W'(left_full);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_mode  <= din.mode;
      s1_kidx  <= din.kernel_index;
      s1_value <= din.value;
      s1_col   <= col_cnt;
      s1_fwd   <= lb_we && (s1_col == col_cnt);
      lb_rd    <= lb_mem[col_cnt];
    end
  end

  assign lb_we  = s1_valid && s1_mode;
  assign lb_cur = s1_fwd ? lb_last : lb_rd;

  always_ff @(posedge clk) begin
    if (lb_we) begin
      lb_mem[s1_col] <= lb_wr;
      lb_last        <= lb_wr;
    end
  end

  // Column vector of the newest sample and the rows above it, oldest first.
  // The line memory word is pushed down by one row as the sample goes in.
  vcc_pkg::sample_t colv [K];

  for (genvar j = 0; j < K; j++) begin : g_colv
    if (j < K - 1) begin : g_old
      assign colv[j] = vcc_pkg::sample_t'(lb_cur[K - 2 - j]);
    end else begin : g_new
      assign colv[j] = s1_value;
    end
  end

  for (genvar i = 0; i < vcc_pkg::LB_ROWS; i++) begin : g_lbwr
    if (i == 0) begin : g_top
      assign lb_wr[i] = s1_value;
    end else begin : g_shift
      assign lb_wr[i] = lb_cur[i - 1];
    end
  end

  // ---------------------------------------------------------------------------
  // Window. Row m of the window holds kernel row m, and the newest column
  // enters at kernel_columns-1, so window element [m][n] meets coefficient
  // [m][n] for every kernel size.
  // ---------------------------------------------------------------------------
  vcc_pkg::sample_t colk [K];
  vcc_pkg::sample_t win  [K][K];

  always_comb begin
    for (int m = 0; m < K; m++) begin
      colk[m] = '0;
      for (int i = 0; i < K; i++) begin
        if (i == m + K - int'(ker_rows)) begin
          colk[m] = colv[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K - 1; j++) begin
          if (j == int'(ker_cols) - 1) begin
            win[i][j] <= colk[i];
          end else if (j < int'(ker_cols) - 1) begin
            win[i][j] <= win[i][j + 1];
          end
        end
        if (K - 1 == int'(ker_cols) - 1) begin
          win[i][K - 1] <= colk[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the window belongs to this stage's sample. Products are formed
  // against the coefficient store, and a coefficient request writes the
  // store on the same edge, so later samples see it and earlier ones do not.
  // ---------------------------------------------------------------------------
  logic                       s2_valid;
  logic                       s2_mode;
  logic [vcc_pkg::KIDX_W-1:0] s2_kidx;
  vcc_pkg::sample_t           s2_value;
  vcc_pkg::tag_t              s2_tag;

  vcc_pkg::sample_t coef [K * K];
  logic signed [vcc_pkg::PROD_W-1:0] prod [K][K];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_tag   <= '0;
    end else begin
      s2_valid <= s1_valid;
      s2_tag   <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    s2_mode  <= s1_mode;
    s2_kidx  <= s1_kidx;
    s2_value <= s1_value;
  end

  always_ff @(posedge clk) begin
    if (s2_valid && !s2_mode && (int'(s2_kidx) < K * K)) begin
      coef[s2_kidx] <= s2_value;
    end
  end

  // Window elements and coefficients outside the kernel in use may hold
  // anything, including cells never written; their products are forced to
  // zero so they never reach the sum.
  always_ff @(posedge clk) begin
    for (int m = 0; m < K; m++) begin
      for (int n = 0; n < K; n++) begin
        if ((m < int'(ker_rows)) && (n < int'(ker_cols))) begin
          prod[m][n] <= win[m][n] * coef[m * K + n];
        end else begin
          prod[m][n] <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3 and 4: row sums, then the full sum straight into the queue.
  // ---------------------------------------------------------------------------
  vcc_pkg::tag_t s3_tag;
  vcc_pkg::tag_t s4_tag;
  logic signed [vcc_pkg::SUM_W-1:0] row_sum  [K];
  logic signed [vcc_pkg::SUM_W-1:0] psum     [K];
  logic signed [vcc_pkg::SUM_W-1:0] full_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag <= '0;
      s4_tag <= '0;
    end else begin
      s3_tag <= s2_tag;
      s4_tag <= s3_tag;
    end
  end

  always_comb begin
    for (int m = 0; m < K; m++) begin
      row_sum[m] = '0;
      for (int n = 0; n < K; n++) begin
        row_sum[m] = row_sum[m] + vcc_pkg::SUM_W'(prod[m][n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int m = 0; m < K; m++) begin
      psum[m] <= row_sum[m];
    end
  end

  always_comb begin
    full_sum = '0;
    for (int m = 0; m < K; m++) begin
      full_sum = full_sum + psum[m];
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue. Input is taken only while the queue can hold every result
  // already in flight plus one more, so the pipeline itself never stalls.
  // ---------------------------------------------------------------------------
  vcc_pkg::result_t fifo [FD];
  vcc_pkg::result_t fifo_wdata;
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic [2:0]       pending;
  logic [AW+1:0]    occ;
  logic             fifo_wr;
  logic             fifo_rd;

  assign fifo_wr = s4_tag.produce;
  assign fifo_rd = dout.valid && dout.ready;
  assign pending = 3'($countones({s1_tag.produce, s2_tag.produce,
                                  s3_tag.produce, s4_tag.produce}));
  assign occ     = (AW + 2)'(count) + (AW + 2)'(pending);
  assign din.ready = (occ < FD);

  always_comb begin
    fifo_wdata.sum     = full_sum;
    fifo_wdata.out_row = s4_tag.top;
    fifo_wdata.out_col = s4_tag.left;
    fifo_wdata.last    = s4_tag.last;
  end

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo[wr_ptr] <= fifo_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (fifo_wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (fifo_rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({fifo_wr, fifo_rd})
        2'b10:   count <= count + (AW + 1)'(1);
        2'b01:   count <= count - (AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  assign dout.valid   = (count != '0);
  assign dout.sum     = fifo[rd_ptr].sum;
  assign dout.out_row = fifo[rd_ptr].out_row;
  assign dout.out_col = fifo[rd_ptr].out_col;
  assign dout.last    = fifo[rd_ptr].last;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // Results already queued plus those in flight never exceed the queue.
  `VCC_ASSERT_ALWAYS(a_queue_room, occ <= FD)
  // The column counter stays inside the configured image width.
  `VCC_ASSERT_ALWAYS(a_col_in_frame, col_ext < img_cols)
  // The last sample of a frame sends both counters back to the first sample.
  `VCC_ASSERT_NEXT(a_frame_wrap, acc_smp && last_now, (col_cnt == '0) && (row_cnt == '0))

endmodule

// ----- tb/tb_valid_2d_cross_correlation.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the valid-mode 2D cross-correlation block. A queue
// of pending requests feeds a clocked driver, a clocked monitor checks every
// result against a predictor kept inside this module, and an initial block
// sets up each image geometry and fills the queue phase by phase.
module tb_valid_2d_cross_correlation;

  localparam int HALF_PERIOD   = 6;
  localparam int STALL_LIMIT   = 5000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 12;    // pipeline depth of four plus margin
  localparam int QUIET_FIRST   = 700;   // window of cycles with no idling
  localparam int QUIET_LAST    = 1400;
  localparam int HOLD_CYCLES   = 300;   // long hold-off of the result side
  localparam int SMALL_BUDGET  = 300;   // image samples in the random phases
  localparam int TALL_SAMPLES  = 200;   // leading part of the tallest frame
  localparam int KERNEL_CELLS  = vcc_pkg::MAX_KERNEL_SIDE * vcc_pkg::MAX_KERNEL_SIDE;

  // One request on the input channel.
  typedef struct {
    logic                       mode;
    logic [vcc_pkg::KIDX_W-1:0] kernel_index;
    vcc_pkg::sample_t           value;
  } request_t;

  logic clk;
  logic rst;

  vcc_cfg_if cfg_bus();
  vcc_in_if  din_bus();
  vcc_out_if dout_bus();

  valid_2d_cross_correlation DUT (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_bus),
    .din  (din_bus),
    .dout (dout_bus)
  );

  // Predictor state: kernel coefficients, a ring of the last image rows, the
  // raster position of the next sample and the geometry in force.
  vcc_pkg::sample_t coef_store [KERNEL_CELLS];
  vcc_pkg::sample_t row_ring [vcc_pkg::MAX_KERNEL_SIDE][vcc_pkg::MAX_COLUMNS];
  int next_col;
  int next_row;
  int img_cols;
  int img_rows;
  int win_rows;
  int win_cols;

  request_t          request_backlog[$];   // requests not yet offered to the block
  vcc_pkg::result_t  predicted_windows[$]; // window sums still to come out
  request_t          head_req;
  request_t          taken_req;
  vcc_pkg::result_t  window_res;
  vcc_pkg::result_t  oldest;
  int requests_queued = 0;
  int requests_taken = 0;
  int error_count = 0;
  int cycle_count = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic quiet;

  // During this stretch neither side idles, so the block runs at full rate.
  assign quiet = (cycle_count >= QUIET_FIRST) && (cycle_count < QUIET_LAST);

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // A register value of zero behaves as one; anything above the top saturates.
  function automatic int clamp_field(int raw, int hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Any geometry write restarts the frame at the top left corner.
  function automatic void apply_geometry(vcc_pkg::cfg_reg_t idx,
                                         logic [vcc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      vcc_pkg::REG_IMAGE_COLUMNS: begin
        img_cols = clamp_field(int'(data[vcc_pkg::IMG_COLS_W-1:0]), vcc_pkg::MAX_COLUMNS);
      end
      vcc_pkg::REG_IMAGE_ROWS: begin
        img_rows = clamp_field(int'(data[vcc_pkg::IMG_ROWS_W-1:0]), vcc_pkg::MAX_IMAGE_ROWS);
      end
      vcc_pkg::REG_KERNEL_ROWS: begin
        win_rows = clamp_field(int'(data[vcc_pkg::KSIDE_W-1:0]), vcc_pkg::MAX_KERNEL_SIDE);
      end
      vcc_pkg::REG_KERNEL_COLUMNS: begin
        win_cols = clamp_field(int'(data[vcc_pkg::KSIDE_W-1:0]), vcc_pkg::MAX_KERNEL_SIDE);
      end
    endcase
    next_col = 0;
    next_row = 0;
  endfunction

  // Takes one accepted request. A coefficient write only updates the store;
  // a sample goes into the row ring and, when the window ending at it lies
  // wholly inside the image, gives the exact sum over that window.
  function automatic bit correlate_sample(request_t req, output vcc_pkg::result_t res);
    int r;
    int c;
    int top;
    int left;
    longint acc;
    bit hit;
    res = '0;
    hit = 1'b0;
    if (req.mode == 1'b0) begin
      // Indices past the last kernel cell are dropped.
      if (req.kernel_index < KERNEL_CELLS) coef_store[req.kernel_index] = req.value;
      return 1'b0;
    end
    r = next_row;
    c = next_col;
    if (c >= img_cols) c = 0;
    if (r >= img_rows) r = 0;
    row_ring[r % vcc_pkg::MAX_KERNEL_SIDE][c] = req.value;
    // A kernel larger than the image gives nothing for the whole frame.
    if (win_rows <= img_rows && win_cols <= img_cols &&
        r + 1 >= win_rows && c + 1 >= win_cols) begin
      top = r + 1 - win_rows;
      left = c + 1 - win_cols;
      acc = 0;
      for (int m = 0; m < win_rows; m++) begin
        for (int n = 0; n < win_cols; n++) begin
          acc += longint'(row_ring[(top + m) % vcc_pkg::MAX_KERNEL_SIDE][left + n]) *
                 longint'(coef_store[m * vcc_pkg::MAX_KERNEL_SIDE + n]);
        end
      end
      res.sum = acc[vcc_pkg::SUM_W-1:0];
      res.out_row = top[vcc_pkg::ROW_OUT_W-1:0];
      res.out_col = left[vcc_pkg::COL_OUT_W-1:0];
      res.last = (r + 1 == img_rows) && (c + 1 == img_cols);
      hit = 1'b1;
    end
    c++;
    if (c >= img_cols) begin
      c = 0;
      r++;
      if (r >= img_rows) r = 0;
    end
    next_col = c;
    next_row = r;
    return hit;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("%0t ns: mismatch on %s, got %0d, predicted %0d", $time, what, got, want);
  endtask

  // Apply side: every request and register write is fed to the predictor at
  // the edge where it is accepted, so the predicted queue follows the block.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        apply_geometry(vcc_pkg::cfg_reg_t'(cfg_bus.index), cfg_bus.data);
      end
      if (din_bus.valid && din_bus.ready) begin
        taken_req.mode = din_bus.mode;
        taken_req.kernel_index = din_bus.kernel_index;
        taken_req.value = din_bus.value;
        if (correlate_sample(taken_req, window_res)) predicted_windows.push_back(window_res);
        requests_taken <= requests_taken + 1;
      end
    end
  end

  // Driver: offers the next pending request whenever the channel is free,
  // skipping about one cycle in nine outside the quiet window.
  always @(posedge clk) begin
    if (rst) begin
      din_bus.valid <= 1'b0;
    end else if (!din_bus.valid || din_bus.ready) begin
      if (request_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 11)) begin
        head_req = request_backlog.pop_front();
        din_bus.valid <= 1'b1;
        din_bus.mode <= head_req.mode;
        din_bus.kernel_index <= head_req.kernel_index;
        din_bus.value <= head_req.value;
      end else begin
        din_bus.valid <= 1'b0;
      end
    end
  end

  // Result side readiness. Once, while a large backlog is still waiting, the
  // result side holds off for a long stretch so that the output queue fills
  // and the block has to stall its input.
  always @(posedge clk) begin
    if (rst) begin
      dout_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      dout_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && request_backlog.size() > 200) begin
      dout_bus.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      dout_bus.ready <= quiet || ($urandom_range(0, 99) >= 11);
    end
  end

  // Monitor: each result is matched field by field with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && dout_bus.valid && dout_bus.ready) begin
      if (predicted_windows.size() == 0) begin
        report_mismatch("result with nothing predicted, sum", dout_bus.sum, 0);
      end else begin
        oldest = predicted_windows.pop_front();
        if (dout_bus.sum !== oldest.sum) report_mismatch("sum", dout_bus.sum, oldest.sum);
        if (dout_bus.out_row !== oldest.out_row) begin
          report_mismatch("out_row", dout_bus.out_row, oldest.out_row);
        end
        if (dout_bus.out_col !== oldest.out_col) begin
          report_mismatch("out_col", dout_bus.out_col, oldest.out_col);
        end
        if (dout_bus.last !== oldest.last) report_mismatch("last", dout_bus.last, oldest.last);
      end
    end
  end

  // Watchdog: a run that stops moving on every channel is a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (din_bus.valid && din_bus.ready) || (dout_bus.valid && dout_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_request(logic mode, int idx, int v);
    request_t req;
    req.mode = mode;
    req.kernel_index = idx[vcc_pkg::KIDX_W-1:0];
    req.value = vcc_pkg::sample_t'(v);
    request_backlog.push_back(req);
    requests_queued++;
  endtask

  // The index field is a don't-care for samples, so it carries noise.
  task automatic push_sample(int v);
    push_request(1'b1, $urandom_range(0, 31), v);
  endtask

  // Style 1 uses only the two extremes, style 2 small values near zero.
  function automatic int pick_value(int style);
    case (style)
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      2: return int'($urandom_range(0, 16)) - 8;
      default: return int'(vcc_pkg::sample_t'($urandom));
    endcase
  endfunction

  // Mostly a value in range, sometimes zero or an oversize small value, and
  // now and then any 13-bit pattern.
  function automatic int pick_raw(int lo, int hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return $urandom_range(0, 8191);
    if (roll < 12) return $urandom_range(0, 7);
    return $urandom_range(lo, hi);
  endfunction

  // Waits until every request is taken and every result is back, then lets
  // the pipeline drain of requests that produce no result.
  task automatic settle();
    while (requests_taken != requests_queued) @(posedge clk);
    while (predicted_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(vcc_pkg::cfg_reg_t idx, int raw);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= raw[vcc_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic configure(int cols, int rows, int krows, int kcols);
    settle();
    write_reg(vcc_pkg::REG_IMAGE_COLUMNS, cols);
    write_reg(vcc_pkg::REG_IMAGE_ROWS, rows);
    write_reg(vcc_pkg::REG_KERNEL_ROWS, krows);
    write_reg(vcc_pkg::REG_KERNEL_COLUMNS, kcols);
  endtask

  // Streams samples; with mixing on, a few coefficient writes (some to
  // indices past the kernel) land in the middle of the frame.
  task automatic run_frames(int count, int style, bit mix_coefs);
    for (int i = 0; i < count; i++) begin
      if (mix_coefs && $urandom_range(0, 99) < 6) begin
        push_request(1'b0, $urandom_range(0, 31), pick_value(style));
      end
      push_sample(pick_value(style));
    end
  endtask

  initial begin
    int raw_cols;
    int raw_rows;
    int frame;
    int count;
    int style;
    int small_samples;

    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = vcc_pkg::REG_IMAGE_COLUMNS;
    cfg_bus.data = '0;
    din_bus.valid = 1'b0;
    din_bus.mode = 1'b0;
    din_bus.kernel_index = '0;
    din_bus.value = '0;
    dout_bus.ready = 1'b0;

    foreach (coef_store[k]) coef_store[k] = '0;
    foreach (row_ring[a, b]) row_ring[a][b] = '0;
    img_cols = 1;
    img_rows = 1;
    win_rows = 1;
    win_cols = 1;
    next_col = 0;
    next_row = 0;
    small_samples = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, first on the reset geometry of a single sample and a
    // single coefficient: every sample is its own frame and ends it. Products
    // of the extremes, and writes past the kernel that must leave it alone.
    push_request(1'b0, 0, -32768);
    push_sample(-32768);
    push_sample(32767);
    push_request(1'b0, 0, 32767);
    push_sample(-32768);
    push_request(1'b0, 31, 16'h5555);
    push_request(1'b0, 25, -1);
    push_sample(-1);
    push_sample(0);

    // A 2x2 kernel on a 2x2 image gives one result per frame. A coefficient
    // written mid-frame must be used by the window that closes after it.
    configure(2, 2, 2, 2);
    push_request(1'b0, 0, 32767);
    push_request(1'b0, 1, -32768);
    push_request(1'b0, 5, -1);
    push_request(1'b0, 6, 1);
    push_sample(-32768);
    push_sample(32767);
    push_sample(1);
    push_request(1'b0, 6, -32768);
    push_sample(-32768);
    push_sample(32767);
    push_sample(32767);
    push_sample(-32768);
    push_sample(-32768);

    // Load the whole kernel so that every later window reads written cells.
    configure(4, 3, 2, 3);
    for (int k = 0; k < KERNEL_CELLS; k++) push_request(1'b0, k, pick_value(0));
    run_frames(24, 0, 1'b1);

    // All registers zero: every one of them acts as one.
    configure(0, 0, 0, 0);
    run_frames(5, 0, 1'b1);

    // Oversize kernel fields saturate to five, larger than a 3x3 image, so
    // samples are counted but the frames give nothing.
    configure(3, 3, 7, 6);
    run_frames(18, 0, 1'b1);

    // Widest image, one row, a 1x5 kernel; the column field saturates.
    configure(2047, 1, 1, 5);
    run_frames(vcc_pkg::MAX_COLUMNS, 0, 1'b0);

    // Full 5x5 kernel on a 5x5 image with extreme values for the largest sums.
    configure(5, 5, 5, 5);
    for (int k = 0; k < KERNEL_CELLS; k++) push_request(1'b0, k, pick_value(1));
    run_frames(75, 1, 1'b0);

    // Tallest image, one column, a 5x1 kernel with the row field saturated;
    // only the top of the frame is streamed before the next geometry.
    configure(1, 8191, 5, 1);
    run_frames(TALL_SAMPLES, 0, 1'b0);

    // Random phases: mostly small images streamed as one to three whole
    // frames, sometimes cut short, with now and then an odd register value.
    while (small_samples < SMALL_BUDGET) begin
      raw_cols = pick_raw(1, 12);
      raw_rows = pick_raw(1, 9);
      frame = clamp_field(raw_cols & 'h7FF, vcc_pkg::MAX_COLUMNS) *
              clamp_field(raw_rows & 'h1FFF, vcc_pkg::MAX_IMAGE_ROWS);
      if (frame > 600) begin
        count = $urandom_range(20, 80);
      end else begin
        count = frame * $urandom_range(1, 3);
        if ($urandom_range(0, 99) < 30) count += $urandom_range(1, frame);
      end
      style = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
      configure(raw_cols, raw_rows, pick_raw(1, 5), pick_raw(1, 5));
      run_frames(count, style, 1'b1);
      small_samples += count;
    end

    settle();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
